### rtl/bbtd_pkg.sv
// Shared types and constants for the BER base-128 tag decoder.
// No dependencies; used by every module in the block.
`timescale 1ns / 1ps

package bbtd_pkg;

  localparam int VALUE_W        = 64;
  localparam int COUNT_W        = 4;
  localparam int VALUE_BITS_DEF = 64;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_TRUNCATED    = 2'd1;
  localparam logic [1:0] ST_BAD_LENGTH   = 2'd2;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd3;

  localparam logic [7:0] BAD_FIRST_BYTE = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] bytes_used;
  } res_t;

  // One parse step: whether a result leaves, and its contents.
  typedef struct packed {
    logic emit;
    res_t res;
  } step_t;

endpackage

### rtl/bbtd_parser.sv
// Parser state (accumulator, byte count, in-value flag) and the per-byte step.
// Depends on bbtd_pkg.
`timescale 1ns / 1ps

module bbtd_parser #(
  parameter int VALUE_BITS = bbtd_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  bbtd_pkg::req_t      item,
  output bbtd_pkg::step_t     step
);

  logic [VALUE_BITS-1:0]        accumulator;
  logic [VALUE_BITS-1:0]        accumulator_next;
  logic [bbtd_pkg::COUNT_W-1:0] byte_count;
  logic [bbtd_pkg::COUNT_W-1:0] byte_count_next;
  logic                         in_value;
  logic                         in_value_next;

  logic [VALUE_BITS-1:0]        acc_shift;
  logic [bbtd_pkg::COUNT_W-1:0] count_inc;
  logic                         overflow;

  // At or above 2^(VALUE_BITS-7): any of the top seven bits set.
  assign overflow  = |accumulator[VALUE_BITS-1 -: 7];
  assign acc_shift = {accumulator[VALUE_BITS-8:0], item.data_byte[6:0]};
  assign count_inc = byte_count + bbtd_pkg::COUNT_W'(1);

  always_comb begin
    step             = '0;
    accumulator_next = accumulator;
    byte_count_next  = byte_count;
    in_value_next    = in_value;
    priority if (item.end_of_buffer) begin
      step.emit       = 1'b1;
      step.res.status = bbtd_pkg::ST_TRUNCATED;
    end else if (!in_value && item.data_byte == bbtd_pkg::BAD_FIRST_BYTE) begin
      step.emit       = 1'b1;
      step.res.status = bbtd_pkg::ST_BAD_LENGTH;
    end else if (overflow) begin
      step.emit       = 1'b1;
      step.res.status = bbtd_pkg::ST_OUT_OF_RANGE;
    end else if (!item.data_byte[7]) begin
      step.emit           = 1'b1;
      step.res.status     = bbtd_pkg::ST_OK;
      step.res.value      = bbtd_pkg::VALUE_W'(acc_shift);
      step.res.bytes_used = count_inc;
    end else begin
      accumulator_next = acc_shift;
      byte_count_next  = count_inc;
      in_value_next    = 1'b1;
    end
    // Any result starts a new value.
    if (step.emit) begin
      accumulator_next = '0;
      byte_count_next  = '0;
      in_value_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      byte_count  <= '0;
      in_value    <= 1'b0;
    end else if (advance) begin
      accumulator <= accumulator_next;
      byte_count  <= byte_count_next;
      in_value    <= in_value_next;
    end
  end

endmodule

### rtl/bbtd_out_reg.sv
// Result register: holds one decoded result until the receiver takes it.
// Depends on bbtd_pkg.
`timescale 1ns / 1ps

module bbtd_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  bbtd_pkg::res_t load_data,
  output logic           free,
  output logic           res_valid,
  input  logic           res_stall,
  output bbtd_pkg::res_t res
);

  logic res_valid_next;

  // Free when empty or being taken this cycle.
  assign free = !res_valid || !res_stall;

  always_comb begin
    res_valid_next = res_valid;
    if (load) begin
      res_valid_next = 1'b1;
    end else if (!res_stall) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_data;
    end
  end

endmodule

### rtl/ber_base128_tag_decoder_top.sv
// Top level of the BER base-128 tag decoder: request register, parser, result register.
// Depends on bbtd_pkg, bbtd_parser and bbtd_out_reg.
`timescale 1ns / 1ps

// Usage:
//   Request channel (req_valid / req_stall / req) carries one byte of the
//   buffer, or an end-of-buffer mark. Result channel (res_valid / res_stall /
//   res) carries status, decoded value and byte count for each value that
//   completes or fails, and for each end-of-buffer mark.
//   A request is taken in the request register; the parser handles it there
//   and any result is loaded into the result register, which drives res_valid.
//   Throughput is one byte per cycle while req_stall stays low: the only loop
//   is the accumulator shift-and-or with its top-bits compare.
//   A held result does not block bytes that give no result; only a byte that
//   gives a result waits while the result register is full and stalled, and
//   then req_stall rises until the receiver drops res_stall.
//   Reset clears both valid flags and returns the parser to waiting for the
//   first byte of a new value with an empty accumulator.
module ber_base128_tag_decoder_top #(
  parameter int VALUE_BITS = bbtd_pkg::VALUE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bbtd_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_stall,
  output bbtd_pkg::res_t res
);

  logic            hold_valid;
  logic            hold_valid_next;
  bbtd_pkg::req_t  hold;
  logic            accept;
  logic            advance;
  logic            out_free;
  bbtd_pkg::step_t step;

  assign advance   = hold_valid && (!step.emit || out_free);
  assign req_stall = hold_valid && !advance;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    hold_valid_next = hold_valid;
    if (accept) begin
      hold_valid_next = 1'b1;
    end else if (advance) begin
      hold_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= req;
    end
  end

  bbtd_parser #(
    .VALUE_BITS (VALUE_BITS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (hold),
    .step    (step)
  );

  bbtd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && step.emit),
    .load_data (step.res),
    .free      (out_free),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  a_err_fields_zero : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != bbtd_pkg::ST_OK) |-> (res.value == '0 && res.bytes_used == '0))
    else $error("error result carries non-zero value or count");

  a_ok_has_bytes : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == bbtd_pkg::ST_OK) |-> (res.bytes_used != '0))
    else $error("ok result with zero bytes used");

  a_emit_loads : assert property (@(posedge clk) disable iff (rst)
    (hold_valid && step.emit && out_free) |=> res_valid)
    else $error("emitted result did not reach the result register");

  a_stall_means_blocked : assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (hold_valid && step.emit && res_valid && res_stall))
    else $error("request stalled without a blocked result");

endmodule
